>>> sv/crc_checked_command_deframer_defines.svh
// Assertion macros shared by the checker of the command deframer.
`ifndef CRC_CHECKED_COMMAND_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_COMMAND_DEFRAMER_DEFINES_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define CCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed in the same cycle");

// Whenever the condition holds, the consequence must hold in the next cycle.
`define CCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed in the following cycle");

`endif

>>> sv/ccd_pkg.sv
// Types, constants and the CRC-16 byte update for the command deframer.
`default_nettype none
package ccd_pkg;

    localparam logic [7:0]  START_BYTE = 8'h2F;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOP    = 16'h8000;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_LEN     = 3'd4,
        PH_PARAM   = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_CRC_LO  = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        KIND_CMD     = 3'd0,
        KIND_ADDR_HI = 3'd1,
        KIND_ADDR_LO = 3'd2,
        KIND_LEN     = 3'd3,
        KIND_PARAM   = 3'd4,
        KIND_END     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] pos;
        logic       crc_ok;
    } t_field;

    typedef struct packed {
        logic   valid;
        t_field field;
    } t_result;

    // CRC-16 XMODEM, MSB first: eight shift steps over one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> sv/ccd_stream_if.sv
// Valid/ready channel interfaces for received bytes and decoded field words.
`default_nettype none
interface ccd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccd_field_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [7:0] field_value;
    logic [7:0] param_position;
    logic       crc_ok;

    modport source (output valid, output field_kind, output field_value,
                    output param_position, output crc_ok, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input param_position, input crc_ok, output ready);
endinterface
`default_nettype wire

>>> sv/ccd_in_stage.sv
// Input register that holds one received byte for the frame decoder.
`default_nettype none
module ccd_in_stage (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ccd_byte_if.sink    i_rx,
    input  wire logic   i_take,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // A held word leaves in the same cycle as the next one arrives.
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule
`default_nettype wire

>>> sv/ccd_frame_fsm.sv
// Frame phase tracking, running CRC and field decoding for one byte a cycle while i_fire is high.
`default_nettype none
module ccd_frame_fsm (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    output ccd_pkg::t_result o_res
);

    ccd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_crc, n_crc;
    logic [8:0]      r_remaining, n_remaining;
    logic [7:0]      r_param_cnt, n_param_cnt;
    logic [7:0]      r_crc_hi, n_crc_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ccd_pkg::PH_HUNT;
            r_crc       <= 16'h0000;
            r_remaining <= 9'd0;
            r_param_cnt <= 8'd0;
            r_crc_hi    <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_param_cnt <= n_param_cnt;
            r_crc_hi    <= n_crc_hi;
        end
    end

    always_comb begin
        logic [15:0] crc_next;
        crc_next    = ccd_pkg::crc16_byte(r_crc, i_byte);
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_param_cnt = r_param_cnt;
        n_crc_hi    = r_crc_hi;

        o_res.valid        = 1'b0;
        o_res.field.kind   = ccd_pkg::KIND_CMD;
        o_res.field.value  = i_byte;
        o_res.field.pos    = 8'd0;
        o_res.field.crc_ok = 1'b0;

        if (i_fire) begin
            unique case (r_phase)
                ccd_pkg::PH_HUNT: begin
                    // Every byte seen while hunting restarts the checksum.
                    n_crc = ccd_pkg::crc16_byte(16'h0000, i_byte);
                    if (i_byte == ccd_pkg::START_BYTE) begin
                        n_phase = ccd_pkg::PH_CMD;
                    end
                end
                ccd_pkg::PH_CMD: begin
                    n_crc            = crc_next;
                    n_phase          = ccd_pkg::PH_ADDR_HI;
                    o_res.valid      = 1'b1;
                    o_res.field.kind = ccd_pkg::KIND_CMD;
                end
                ccd_pkg::PH_ADDR_HI: begin
                    n_crc            = crc_next;
                    n_phase          = ccd_pkg::PH_ADDR_LO;
                    o_res.valid      = 1'b1;
                    o_res.field.kind = ccd_pkg::KIND_ADDR_HI;
                end
                ccd_pkg::PH_ADDR_LO: begin
                    n_crc            = crc_next;
                    n_phase          = ccd_pkg::PH_LEN;
                    o_res.valid      = 1'b1;
                    o_res.field.kind = ccd_pkg::KIND_ADDR_LO;
                end
                ccd_pkg::PH_LEN: begin
                    n_crc            = crc_next;
                    // A length byte of zero stands for 256 parameter bytes.
                    n_remaining      = {(i_byte == 8'd0), i_byte};
                    n_param_cnt      = 8'd0;
                    n_phase          = ccd_pkg::PH_PARAM;
                    o_res.valid      = 1'b1;
                    o_res.field.kind = ccd_pkg::KIND_LEN;
                end
                ccd_pkg::PH_PARAM: begin
                    n_crc            = crc_next;
                    n_param_cnt      = r_param_cnt + 8'd1;
                    if (r_remaining <= 9'd1) begin
                        n_remaining = 9'd0;
                        n_phase     = ccd_pkg::PH_CRC_HI;
                    end else begin
                        n_remaining = r_remaining - 9'd1;
                    end
                    o_res.valid      = 1'b1;
                    o_res.field.kind = ccd_pkg::KIND_PARAM;
                    o_res.field.pos  = r_param_cnt;
                end
                ccd_pkg::PH_CRC_HI: begin
                    n_crc_hi = i_byte;
                    n_phase  = ccd_pkg::PH_CRC_LO;
                end
                ccd_pkg::PH_CRC_LO: begin
                    n_crc              = 16'h0000;
                    n_phase            = ccd_pkg::PH_HUNT;
                    o_res.valid        = 1'b1;
                    o_res.field.kind   = ccd_pkg::KIND_END;
                    o_res.field.value  = 8'd0;
                    o_res.field.crc_ok = ({r_crc_hi, i_byte} == r_crc);
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/ccd_out_stage.sv
// Output register that presents one decoded field word until it is taken.
`default_nettype none
module ccd_out_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire ccd_pkg::t_field i_field,
    output logic              o_free,
    ccd_field_if.source       o_field
);

    logic             r_valid;
    ccd_pkg::t_field  r_field;

    // The register can be refilled in the cycle its word is taken.
    assign o_free = !r_valid || o_field.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_field <= i_field;
        end
    end

    assign o_field.valid          = r_valid;
    assign o_field.field_kind     = r_field.kind;
    assign o_field.field_value    = r_field.value;
    assign o_field.param_position = r_field.pos;
    assign o_field.crc_ok         = r_field.crc_ok;

endmodule
`default_nettype wire

>>> sv/crc_checked_command_deframer.sv
// A byte held in the input register is decoded once the output register can take a word,
// and its word, if any, is registered there; CRC-16 update and phase step are combinational.
// Throughput: one byte per cycle while the output register is free, set by those steps.
// Bytes that give no word (hunting, start byte, CRC high byte) pass at the same rate.
// Reset is synchronous and active low: it returns to hunting, clears the CRC and counters,
// and empties the input and output registers.
`default_nettype none
module crc_checked_command_deframer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ccd_byte_if.sink    i_rx,
    ccd_field_if.source o_field
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_free;
    logic             fire;
    ccd_pkg::t_result res;

    // A held byte is decoded as soon as the output register can take its word.
    assign fire = in_valid && out_free;

    ccd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    ccd_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    ccd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res.valid),
        .i_field (res.field),
        .o_free  (out_free),
        .o_field (o_field)
    );

endmodule
`default_nettype wire

>>> sv/ccd_checker.sv
// Port-level checks on the decoded field words of the command deframer.
`default_nettype none
`include "crc_checked_command_deframer_defines.svh"
module ccd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_kind,
    input wire logic [7:0] i_value,
    input wire logic [7:0] i_pos,
    input wire logic       i_crc_ok
);

    // Only a frame end word carries a CRC verdict.
    `CCD_ASSERT_SAME(a_crc_ok_only_end, i_clk, i_rst_n, i_out_valid && (i_kind != ccd_pkg::KIND_END), !i_crc_ok)

    // Only a parameter word carries a position.
    `CCD_ASSERT_SAME(a_pos_only_param, i_clk, i_rst_n, i_out_valid && (i_kind != ccd_pkg::KIND_PARAM), i_pos == 8'd0)

    // A frame end word has no byte value.
    `CCD_ASSERT_SAME(a_end_value_zero, i_clk, i_rst_n, i_out_valid && (i_kind == ccd_pkg::KIND_END), i_value == 8'd0)

    // A stalled word stays offered and unchanged.
    `CCD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_value) && $stable(i_pos) && $stable(i_crc_ok))

endmodule

bind crc_checked_command_deframer ccd_checker u_ccd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_field.valid),
    .i_out_ready (o_field.ready),
    .i_kind      (o_field.field_kind),
    .i_value     (o_field.field_value),
    .i_pos       (o_field.param_position),
    .i_crc_ok    (o_field.crc_ok)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the CRC-checked command deframer: framed byte traffic in, field words checked.
module tb;
    import ccd_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int TARGET_BYTES = 1150;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 20;

    logic i_clk;
    logic i_rst_n;

    ccd_byte_if  rx_if ();
    ccd_field_if field_if ();

    crc_checked_command_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_field (field_if)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Stream of bytes still to be offered, and field words still awaited.
    logic [7:0] pending_bytes[$];
    t_field     expected_fields[$];
    logic [7:0] frame_params[$];

    // Independent copy of the deframer state.
    t_phase      dfr_phase;
    logic [15:0] dfr_crc;
    logic [8:0]  dfr_remaining;
    logic [7:0]  dfr_param_idx;
    logic [7:0]  dfr_crc_hi;

    int errors;
    int bytes_accepted;
    int words_checked;
    int ends_seen;
    int ends_good;
    int frames_built;
    int frames_corrupt;
    int frame_bytes;
    int cycle_count;

    int burst_left;
    int gap_left;
    logic offer;

    int hold_left;
    bit hold_done;
    int stall_mode;
    int stall_mode_left;
    int stall_tick;
    logic rdy;

    // Bitwise CRC-16 with polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_field f;
        f = '{kind: KIND_CMD, value: b, pos: 8'h00, crc_ok: 1'b0};
        case (dfr_phase)
            PH_HUNT: begin
                dfr_crc = crc16_xmodem_step(16'h0000, b);
                if (b == START_BYTE) dfr_phase = PH_CMD;
            end
            PH_CMD: begin
                dfr_crc   = crc16_xmodem_step(dfr_crc, b);
                dfr_phase = PH_ADDR_HI;
                expected_fields.push_back(f);
            end
            PH_ADDR_HI: begin
                dfr_crc   = crc16_xmodem_step(dfr_crc, b);
                dfr_phase = PH_ADDR_LO;
                f.kind    = KIND_ADDR_HI;
                expected_fields.push_back(f);
            end
            PH_ADDR_LO: begin
                dfr_crc   = crc16_xmodem_step(dfr_crc, b);
                dfr_phase = PH_LEN;
                f.kind    = KIND_ADDR_LO;
                expected_fields.push_back(f);
            end
            PH_LEN: begin
                dfr_crc       = crc16_xmodem_step(dfr_crc, b);
                // A length byte of zero stands for a full 256 parameters.
                dfr_remaining = (b == 8'h00) ? 9'd256 : {1'b0, b};
                dfr_param_idx = 8'h00;
                dfr_phase     = PH_PARAM;
                f.kind        = KIND_LEN;
                expected_fields.push_back(f);
            end
            PH_PARAM: begin
                dfr_crc       = crc16_xmodem_step(dfr_crc, b);
                f.kind        = KIND_PARAM;
                f.pos         = dfr_param_idx;
                dfr_param_idx = dfr_param_idx + 8'd1;
                if (dfr_remaining <= 9'd1) begin
                    dfr_remaining = 9'd0;
                    dfr_phase     = PH_CRC_HI;
                end else begin
                    dfr_remaining = dfr_remaining - 9'd1;
                end
                expected_fields.push_back(f);
            end
            PH_CRC_HI: begin
                dfr_crc_hi = b;
                dfr_phase  = PH_CRC_LO;
            end
            default: begin
                f.kind    = KIND_END;
                f.value   = 8'h00;
                f.crc_ok  = ({dfr_crc_hi, b} == dfr_crc);
                dfr_phase = PH_HUNT;
                dfr_crc   = 16'h0000;
                expected_fields.push_back(f);
            end
        endcase
    endtask

    // Builds a frame around the parameters in frame_params; crc_flip spoils the checksum.
    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] addr_hi,
                              input logic [7:0] addr_lo, input logic [7:0] len_byte,
                              input logic [15:0] crc_flip);
        logic [7:0]  hdr[5];
        logic [15:0] c;
        c      = 16'h0000;
        hdr[0] = START_BYTE;
        hdr[1] = cmd;
        hdr[2] = addr_hi;
        hdr[3] = addr_lo;
        hdr[4] = len_byte;
        foreach (hdr[i]) begin
            c = crc16_xmodem_step(c, hdr[i]);
            pending_bytes.push_back(hdr[i]);
        end
        foreach (frame_params[i]) begin
            c = crc16_xmodem_step(c, frame_params[i]);
            pending_bytes.push_back(frame_params[i]);
        end
        c = c ^ crc_flip;
        pending_bytes.push_back(c[15:8]);
        pending_bytes.push_back(c[7:0]);
        frame_bytes    += 7 + frame_params.size();
        frames_built   += 1;
        frames_corrupt += (crc_flip != 16'h0000);
        frame_params.delete();
    endtask

    task automatic push_random_frame(input logic [7:0] len_byte);
        int n;
        logic [15:0] flip;
        n = (len_byte == 8'h00) ? 256 : len_byte;
        for (int i = 0; i < n; i++) begin
            frame_params.push_back(($urandom_range(0, 7) == 0) ? START_BYTE
                                                                : 8'($urandom));
        end
        flip = ($urandom_range(0, 3) == 0) ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000;
        push_frame(8'($urandom), 8'($urandom), 8'($urandom), len_byte, flip);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offer = rx_if.valid;
            if (rx_if.valid && rx_if.ready) begin
                deframe_byte(rx_if.rx_byte);
                bytes_accepted++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() > 0) begin
                    rx_if.rx_byte <= pending_bytes.pop_front();
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            rx_if.valid <= offer;
        end
    end

    // Receiver: stall pattern changes at random intervals, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            field_if.ready <= 1'b0;
            hold_left       = 0;
            hold_done       = 1'b0;
            stall_mode_left = 0;
            stall_tick      = 0;
        end else begin
            stall_tick++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && bytes_accepted >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end else begin
                if (stall_mode_left == 0) begin
                    stall_mode      = $urandom_range(0, 3);
                    stall_mode_left = $urandom_range(16, 96);
                end
                stall_mode_left--;
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (stall_tick % 4 == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            field_if.ready <= rdy;
        end
    end

    // Output monitor: every accepted field word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_field got;
        t_field want;
        if (i_rst_n && field_if.valid && field_if.ready) begin
            got = '{kind: t_kind'(field_if.field_kind), value: field_if.field_value,
                    pos: field_if.param_position, crc_ok: field_if.crc_ok};
            words_checked++;
            if (expected_fields.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word kind=%0d value=%h pos=%0d ok=%0d",
                             $time, got.kind, got.value, got.pos, got.crc_ok);
            end else begin
                want = expected_fields.pop_front();
                if (want.kind == KIND_END) begin
                    ends_seen++;
                    ends_good += want.crc_ok;
                end
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch expected kind=%0d value=%h pos=%0d ok=%0d, %s",
                                 $time, want.kind, want.value, want.pos, want.crc_ok,
                                 $sformatf("actual kind=%0d value=%h pos=%0d ok=%0d",
                                           got.kind, got.value, got.pos, got.crc_ok));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish, %0d words still awaited",
                     $time, expected_fields.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int r;
        int n;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        field_if.ready = 1'b0;
        dfr_phase      = PH_HUNT;
        dfr_crc        = 16'h0000;
        dfr_remaining  = 9'd0;
        dfr_param_idx  = 8'h00;
        dfr_crc_hi     = 8'h00;
        errors = 0; bytes_accepted = 0; words_checked = 0; ends_seen = 0; ends_good = 0;
        frames_built = 0; frames_corrupt = 0; frame_bytes = 0; cycle_count = 0;

        // Directed: noise at both byte extremes, a good frame carrying the start byte
        // as a parameter, and a frame with a spoilt checksum and extreme field values.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        frame_params.push_back(START_BYTE);
        push_frame(8'h00, 8'hFF, 8'h00, 8'h01, 16'h0000);
        frame_params.push_back(8'h00);
        frame_params.push_back(8'hFF);
        push_frame(8'hFF, 8'h00, 8'hFF, 8'h02, 16'h8000);

        // Random: mostly well-formed frames, with noise and cut-short frames mixed in.
        while (frame_bytes < TARGET_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                n = $urandom_range(1, 4);
                repeat (n) pending_bytes.push_back(8'($urandom));
            end else if (r < 12) begin
                pending_bytes.push_back(START_BYTE);
                n = $urandom_range(1, 6);
                repeat (n) pending_bytes.push_back(8'($urandom));
                frame_bytes += n + 1;
            end else if (frames_built == 10) begin
                push_random_frame(8'h00);
            end else if (frames_built == 25) begin
                push_random_frame(8'hFF);
            end else if (r < 20) begin
                push_random_frame(8'($urandom_range(1, 40)));
            end else begin
                push_random_frame(8'($urandom_range(1, 12)));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || rx_if.valid) @(posedge i_clk);
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d bytes: %0d frames built, %0d of them with a spoilt checksum.",
                 bytes_accepted, frames_built, frames_corrupt);
        $display("Checked %0d field words, %0d frame ends (%0d with a good checksum), %0d errors.",
                 words_checked, ends_seen, ends_good, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ccd_pkg.sv
sv/ccd_stream_if.sv
sv/ccd_in_stage.sv
sv/ccd_frame_fsm.sv
sv/ccd_out_stage.sv
sv/crc_checked_command_deframer.sv
sv/ccd_checker.sv
tb/tb.sv
